>>> hw/rtl/priority_ordered_entry_list_unit_defines.svh
// ----------------------------------------------------------------------------
// priority ordered entry list: assertion macros
// shared property templates, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_ENTRY_LIST_UNIT_DEFINES_SVH
`define PRIORITY_ORDERED_ENTRY_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define POL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// sizes, codes and request/response types of the priority ordered entry list
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int LIST_DEPTH    = 64;
	localparam int HANDLE_BITS   = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int IDX_BITS      = $clog2(LIST_DEPTH);
	localparam int CNT_BITS      = $clog2(LIST_DEPTH + 1);

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	typedef logic [HANDLE_BITS-1:0]   handle_t;
	typedef logic [PRIORITY_BITS-1:0] prio_t;

	typedef struct packed {
		logic [1:0] operation;
		handle_t    item_handle;
		prio_t      item_priority;
		logic       item_kind;
		logic [5:0] read_index;
	} in_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CNT_BITS-1:0] entry_total;
		handle_t             read_handle;
		prio_t               read_priority;
	} out_rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic       eval;
		logic       mode;
		handle_t    item_handle;
		prio_t      item_priority;
		logic [5:0] read_index;
	} cell_cmd_t;

	// per-cell data movement for the commit cycle
	typedef struct packed {
		logic load_new;
		logic take_prev;
		logic take_next;
	} cell_move_t;

	// per-cell compare results
	typedef struct packed {
		logic nonlt;
		logic match;
		logic sel;
	} cell_flags_t;

endpackage

>>> hw/rtl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// one list slot: holds an entry, compares it against the request, and moves
// data to or from its neighbors on commit
// ----------------------------------------------------------------------------
module pol_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pol_pkg::IDX_BITS-1:0]      cell_idx,
	input  logic [pol_pkg::CNT_BITS-1:0]      fill,
	input  pol_pkg::cell_cmd_t                cmd,
	input  pol_pkg::cell_move_t               move,
	input  pol_pkg::handle_t                  prev_handle,
	input  pol_pkg::prio_t                    prev_prio,
	input  pol_pkg::handle_t                  next_handle,
	input  pol_pkg::prio_t                    next_prio,
	output pol_pkg::handle_t                  handle,
	output pol_pkg::prio_t                    prio,
	output pol_pkg::cell_flags_t              flags
);

	pol_pkg::handle_t     handle_q;
	pol_pkg::prio_t       prio_q;
	pol_pkg::cell_flags_t flags_q;
	logic                 occupied;

	assign occupied = pol_pkg::CNT_BITS'(cell_idx) < fill;

	// moves exclude each other; with none the slot keeps its entry
	always_ff @(posedge clk) begin
		if (move.load_new) begin
			handle_q <= cmd.item_handle;
			prio_q   <= cmd.item_priority;
		end else if (move.take_prev) begin
			handle_q <= prev_handle;
			prio_q   <= prev_prio;
		end else if (move.take_next) begin
			handle_q <= next_handle;
			prio_q   <= next_prio;
		end
	end

	// nonlt: this entry blocks an insert from moving further up the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmd.eval) begin
			flags_q.nonlt <= occupied && (cmd.mode || (prio_q >= cmd.item_priority));
			flags_q.match <= occupied && (handle_q == cmd.item_handle);
			flags_q.sel   <= occupied && (32'(cell_idx) == 32'(cmd.read_index));
		end
	end

	assign handle = handle_q;
	assign prio   = prio_q;
	assign flags  = flags_q;

endmodule

>>> hw/rtl/priority_ordered_entry_list_unit.sv
// ----------------------------------------------------------------------------
// priority_ordered_entry_list_unit
// flow: an accepted request passes the compare state and then the commit state of the
//   cell chain; the result register is loaded on commit, which waits while a held
//   result is stalled; a new request is accepted while idle or as the previous one commits
// reset: arst_n clears the fill count, mode and handshake state at once;
//   slot contents are not reset and only slots below the fill count are used
// ----------------------------------------------------------------------------
`include "priority_ordered_entry_list_unit_defines.svh"

module priority_ordered_entry_list_unit (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  pol_pkg::in_req_t  in_data,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output pol_pkg::out_rsp_t out_data,
	// mode register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	localparam int DEPTH = pol_pkg::LIST_DEPTH;

	// controller states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EVAL   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]                   state_q;
	logic                         mode_q;
	logic [pol_pkg::CNT_BITS-1:0] fill_q;
	pol_pkg::in_req_t             req_q;
	logic                         out_valid_q;
	pol_pkg::out_rsp_t            out_data_q;

	logic in_fire;
	logic out_fire;
	logic commit_fire;

	// cell chain wiring
	pol_pkg::handle_t     h_arr [DEPTH];
	pol_pkg::prio_t       p_arr [DEPTH];
	pol_pkg::cell_flags_t f_arr [DEPTH];
	pol_pkg::cell_move_t  m_arr [DEPTH];
	logic [DEPTH-1:0]     nonlt_vec;
	logic [DEPTH-1:0]     match_vec;
	logic [DEPTH-1:0]     sel_vec;
	pol_pkg::cell_cmd_t   cmd;

	// decode of the request in its commit cycle
	logic             kind_ok;
	logic             list_full;
	logic             found;
	logic             ins_ok;
	logic             rem_ok;
	logic             wr_ins;
	logic             wr_rem;
	logic [1:0]       status;
	pol_pkg::handle_t rd_handle;
	pol_pkg::prio_t   rd_prio;
	logic [pol_pkg::CNT_BITS-1:0] fill_next;

	// handshakes: a new request may enter in the same cycle the previous one commits
	assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	assign in_stall    = !((state_q == ST_IDLE) || commit_fire);
	assign in_fire     = in_valid && !in_stall;
	assign out_fire    = out_valid_q && !out_stall;
	assign cfg_ready   = 1'b1;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// controller: idle -> compare (cells latch flags) -> commit (cells move data)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_fire) state_q <= in_fire ? ST_EVAL : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request holding register
	always_ff @(posedge clk) begin
		if (in_fire) req_q <= in_data;
	end

	// broadcast to the cells
	always_comb begin
		cmd.eval          = (state_q == ST_EVAL);
		cmd.mode          = mode_q;
		cmd.item_handle   = req_q.item_handle;
		cmd.item_priority = req_q.item_priority;
		cmd.read_index    = req_q.read_index;
	end

	// request decode against the latched cell flags
	assign kind_ok   = (req_q.item_kind == mode_q);
	assign list_full = (fill_q == pol_pkg::CNT_BITS'(DEPTH));
	assign found     = |match_vec;
	assign ins_ok    = (req_q.operation == pol_pkg::OP_INSERT) && kind_ok && !list_full;
	assign rem_ok    = (req_q.operation == pol_pkg::OP_REMOVE) && found;
	assign wr_ins    = commit_fire && ins_ok;
	assign wr_rem    = commit_fire && rem_ok;

	always_comb begin
		fill_next = fill_q;
		if (ins_ok) fill_next = fill_q + pol_pkg::CNT_BITS'(1);
		else if (rem_ok) fill_next = fill_q - pol_pkg::CNT_BITS'(1);
	end

	always_comb begin
		status = pol_pkg::STATUS_DONE;
		unique case (req_q.operation)
			pol_pkg::OP_INSERT: begin
				if (!kind_ok) status = pol_pkg::STATUS_MISMATCH;
				else if (list_full) status = pol_pkg::STATUS_FULL;
			end
			pol_pkg::OP_REMOVE: begin
				if (!found) status = pol_pkg::STATUS_NOT_FOUND;
			end
			pol_pkg::OP_READ: begin
				// sel is only set for an occupied slot, so none set means out of range
				if (!(|sel_vec)) status = pol_pkg::STATUS_FULL;
			end
			default: begin
				status = pol_pkg::STATUS_DONE;
			end
		endcase
	end

	// read port: and-or over the one-hot selected cell
	always_comb begin
		rd_handle = '0;
		rd_prio   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_handle = rd_handle | (h_arr[i] & {pol_pkg::HANDLE_BITS{sel_vec[i]}});
			rd_prio   = rd_prio | (p_arr[i] & {pol_pkg::PRIORITY_BITS{sel_vec[i]}});
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (commit_fire) begin
			fill_q <= fill_next;
		end
	end

	// result register, loaded on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			out_data_q.status      <= status;
			out_data_q.entry_total <= fill_next;
			if (req_q.operation == pol_pkg::OP_READ) begin
				out_data_q.read_handle   <= rd_handle;
				out_data_q.read_priority <= rd_prio;
			end else begin
				out_data_q.read_handle   <= '0;
				out_data_q.read_priority <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// cell chain
	// insert: the new entry lands just above the highest blocking entry; cells above it
	//   take from their lower neighbor (in unordered mode every occupied cell blocks)
	// remove: every cell but the last at or above the first match takes from its upper neighbor
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic blk_here;
			logic blk_below;
			logic hit_upto;

			assign blk_here = |(nonlt_vec >> gi);
			assign hit_upto = |(match_vec << (DEPTH - 1 - gi));

			if (gi == 0) begin : g_first
				assign blk_below = 1'b1;
			end else begin : g_rest
				assign blk_below = |(nonlt_vec >> (gi - 1));
			end

			assign m_arr[gi].load_new  = wr_ins && !blk_here && blk_below;
			assign m_arr[gi].take_prev = wr_ins && !blk_below;
			assign m_arr[gi].take_next = wr_rem && hit_upto && (gi < DEPTH - 1);

			assign nonlt_vec[gi] = f_arr[gi].nonlt;
			assign match_vec[gi] = f_arr[gi].match;
			assign sel_vec[gi]   = f_arr[gi].sel;

			if (gi == 0) begin : g_head
				if (DEPTH > 1) begin : g_link
					pol_cell u_cell (
						.clk         (clk),
						.arst_n      (arst_n),
						.cell_idx    (pol_pkg::IDX_BITS'(gi)),
						.fill        (fill_q),
						.cmd         (cmd),
						.move        (m_arr[gi]),
						.prev_handle ('0),
						.prev_prio   ('0),
						.next_handle (h_arr[gi+1]),
						.next_prio   (p_arr[gi+1]),
						.handle      (h_arr[gi]),
						.prio        (p_arr[gi]),
						.flags       (f_arr[gi])
					);
				end
			end else if (gi == DEPTH - 1) begin : g_tail
				pol_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cell_idx    (pol_pkg::IDX_BITS'(gi)),
					.fill        (fill_q),
					.cmd         (cmd),
					.move        (m_arr[gi]),
					.prev_handle (h_arr[gi-1]),
					.prev_prio   (p_arr[gi-1]),
					.next_handle ('0),
					.next_prio   ('0),
					.handle      (h_arr[gi]),
					.prio        (p_arr[gi]),
					.flags       (f_arr[gi])
				);
			end else begin : g_mid
				pol_cell u_cell (
					.clk         (clk),
					.arst_n      (arst_n),
					.cell_idx    (pol_pkg::IDX_BITS'(gi)),
					.fill        (fill_q),
					.cmd         (cmd),
					.move        (m_arr[gi]),
					.prev_handle (h_arr[gi-1]),
					.prev_prio   (p_arr[gi-1]),
					.next_handle (h_arr[gi+1]),
					.next_prio   (p_arr[gi+1]),
					.handle      (h_arr[gi]),
					.prio        (p_arr[gi]),
					.flags       (f_arr[gi])
				);
			end
		end
	endgenerate

	// checks
	`POL_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= pol_pkg::CNT_BITS'(DEPTH), "fill count past depth")
	`POL_ASSERT_SAME(a_sel_onehot, state_q == ST_COMMIT, $onehot0(sel_vec), "several read selects")
	`POL_ASSERT_NEXT(a_ins_count, wr_ins, fill_q == $past(fill_q) + pol_pkg::CNT_BITS'(1), "insert count")
	`POL_ASSERT_NEXT(a_accept_eval, in_fire, state_q == ST_EVAL, "accepted request not evaluated")

endmodule
